// ===== sv/gimbal_pkg.sv =====
// ----------------------------------------------------------------------------
// gimbal_pkg
// Shared types, schedule codes, register indexes and gain table for the
// three-axis gimbal state-feedback controller.
// ----------------------------------------------------------------------------
package gimbal_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT     = 2'd3;

    localparam logic [23:0] GYRO_SCALE_RST    = 24'd17873;
    localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd83886;
    localparam logic [30:0] LIMIT_RST         = 31'h7FFF_FFFF;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Schedule positions. Named after the product issued at that step; the
    // product issued one step earlier is consumed in the same cycle.
    typedef enum logic [4:0] {
        ST_MUL_IPHI = 5'd0,
        ST_MUL_ITHT = 5'd1,
        ST_MUL_IPSI = 5'd2,
        ST_MUL_P    = 5'd3,
        ST_MUL_Q    = 5'd4,
        ST_MUL_R    = 5'd5,
        ST_MUL_A0   = 5'd6,
        ST_MUL_A1   = 5'd7,
        ST_MUL_A2   = 5'd8,
        ST_MUL_A3   = 5'd9,
        ST_MUL_A4   = 5'd10,
        ST_MUL_A5   = 5'd11,
        ST_MUL_B0   = 5'd12,
        ST_MUL_B1   = 5'd13,
        ST_MUL_B2   = 5'd14,
        ST_MUL_B3   = 5'd15,
        ST_MUL_B4   = 5'd16,
        ST_MUL_B5   = 5'd17,
        ST_MUL_Y0   = 5'd18,
        ST_MUL_Y1   = 5'd19,
        ST_MUL_Y2   = 5'd20,
        ST_Y_LAST   = 5'd21,
        ST_ROUND_Y  = 5'd22,
        ST_FINISH   = 5'd23,
        ST_CHECK    = 5'd24
    } t_step;

    typedef struct packed {
        logic  load;   // capture input item
        logic  run;    // schedule step valid
        t_step step;
        logic  emit;   // load output registers
    } t_dp_cmd;

    typedef struct packed {
        logic fault;
    } t_dp_stat;

    // Normal-mode gains, signed Q.24, rounded half away from zero.
    // Order: a terms (p q phi tht phi_int tht_int), b terms, yaw terms.
    function automatic logic signed [29:0] gain_q24(input logic [3:0] idx);
        logic signed [29:0] g;
        case (idx)
            4'd0:    g = -30'sd983556;
            4'd1:    g =  30'sd677820;
            4'd2:    g = -30'sd15904750;
            4'd3:    g =  30'sd12779927;
            4'd4:    g = -30'sd343342370;
            4'd5:    g =  30'sd151173957;
            4'd6:    g =  30'sd216188;
            4'd7:    g =  30'sd1063976;
            4'd8:    g = -30'sd516945;
            4'd9:    g =  30'sd16496114;
            4'd10:   g =  30'sd151173957;
            4'd11:   g =  30'sd343342370;
            4'd12:   g =  30'sd1087375;
            4'd13:   g =  30'sd9080433;
            4'd14:   g =  30'sd167772160;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/gimbal_ctrl.sv =====
// ----------------------------------------------------------------------------
// gimbal_ctrl
// Sequencer: accepts an item, steps the datapath schedule, parks the
// result until the output register is free.
// ----------------------------------------------------------------------------
module gimbal_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  gimbal_pkg::t_dp_stat i_stat,
    output gimbal_pkg::t_dp_cmd  o_cmd
);

    gimbal_pkg::t_state r_state, n_state;
    gimbal_pkg::t_step  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;
    logic               w_emit;

    assign w_accept = i_in_valid && (r_state == gimbal_pkg::S_IDLE);
    assign w_emit   = (r_state == gimbal_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_step  = gimbal_pkg::ST_MUL_IPHI;
        unique case (r_state)
            gimbal_pkg::S_IDLE: begin
                if (w_accept) begin
                    // a latched fault skips the schedule: state stays frozen
                    n_state = i_stat.fault ? gimbal_pkg::S_DONE : gimbal_pkg::S_RUN;
                end
            end
            gimbal_pkg::S_RUN: begin
                if (r_step == gimbal_pkg::ST_CHECK) begin
                    n_state = gimbal_pkg::S_DONE;
                end else begin
                    n_step = gimbal_pkg::t_step'(r_step + 5'd1);
                end
            end
            gimbal_pkg::S_DONE: begin
                if (w_emit) begin
                    n_state = gimbal_pkg::S_IDLE;
                end
            end
            default: n_state = gimbal_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gimbal_pkg::S_IDLE;
            r_step      <= gimbal_pkg::ST_MUL_IPHI;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != gimbal_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.run  = (r_state == gimbal_pkg::S_RUN);
    assign o_cmd.step = r_step;
    assign o_cmd.emit = w_emit;

`ifndef ASSERT_OFF
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gimbal_pkg::S_RUN) |-> (r_step == gimbal_pkg::ST_MUL_IPHI))
        else $error("step counter moved outside RUN");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gimbal_pkg::S_RUN && r_step != gimbal_pkg::ST_CHECK)
        |=> (r_state == gimbal_pkg::S_RUN))
        else $error("schedule left before final step");

    a_fault_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_stat.fault) |=> (r_state == gimbal_pkg::S_DONE))
        else $error("faulted item entered the schedule");

    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gimbal_pkg::S_DONE && r_out_valid && i_out_stall)
        |=> (r_state == gimbal_pkg::S_DONE && r_out_valid))
        else $error("result overwrote a stalled output");
`endif

endmodule

// ===== sv/gimbal_dp.sv =====
// ----------------------------------------------------------------------------
// gimbal_dp
// Datapath: shared 32x30 multiplier, 64-bit accumulator, integrators,
// neutrals, fault latch, configuration and output registers.
// ----------------------------------------------------------------------------
module gimbal_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gimbal_pkg::t_dp_cmd                   i_cmd,
    output gimbal_pkg::t_dp_stat                  o_stat,
    input  logic                                  i_cfg_we,
    input  logic [gimbal_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gimbal_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [15:0]                    i_roll_rate_raw,
    input  logic signed [15:0]                    i_pitch_rate_raw,
    input  logic signed [15:0]                    i_yaw_rate_raw,
    input  logic signed [15:0]                    i_roll_angle,
    input  logic signed [15:0]                    i_pitch_angle,
    input  logic signed [15:0]                    i_yaw_angle,
    input  logic                                  i_starting,
    output logic signed [31:0]                    o_coupled_cmd_a,
    output logic signed [31:0]                    o_coupled_cmd_b,
    output logic signed [31:0]                    o_yaw_motor_command,
    output logic                                  o_fault
);

    // saturate a 40-bit signed value to 32 bits
    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v[39:31] == '0 || v[39:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // round Q.40 sum to Q16.16 (half up) and saturate
    function automatic logic signed [31:0] round_q24(input logic signed [63:0] acc);
        logic signed [63:0] t;
        t = acc + 64'sd8388608;
        return sat40(signed'(t[63:24]));
    endfunction

    // |cmd - neutral| > limit, exact
    function automatic logic beyond(input logic signed [31:0] cmd,
                                    input logic signed [31:0] ntrl,
                                    input logic [30:0] lim);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = {cmd[31], cmd} - {ntrl[31], ntrl};
        m = d[32] ? 33'(-d) : 33'(d);
        return m > {2'b00, lim};
    endfunction

    // configuration
    logic [23:0] r_gyro_scale, r_sample_period;
    logic [30:0] r_tilt_limit, r_yaw_limit;

    // captured item
    logic signed [15:0] r_roll_raw, r_pitch_raw, r_yaw_raw;
    logic signed [15:0] r_phi, r_tht, r_psi;
    logic               r_start;

    // persistent state
    logic signed [31:0] r_roll_int, r_pitch_int, r_yaw_int;
    logic signed [31:0] r_ntrl_a, r_ntrl_b, r_ntrl_y;
    logic               r_fault;

    // working registers
    logic signed [61:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_p, r_q, r_r;
    logic signed [31:0] r_cmd_a, r_cmd_b, r_cmd_y;

    logic signed [31:0] w_mul_a;
    logic signed [29:0] w_mul_b;
    logic [3:0]         w_goff;
    logic signed [29:0] w_gain;
    logic signed [31:0] w_phi8, w_tht8, w_psi8;
    logic signed [31:0] w_int_old;
    logic signed [31:0] w_int_new;
    logic signed [63:0] w_prod64;
    logic signed [63:0] w_acc_sum;
    logic signed [31:0] w_round;
    logic signed [31:0] w_st_a, w_st_b;
    logic               w_beyond;

    assign w_phi8 = {{13{r_phi[15]}}, r_phi, 3'b000};
    assign w_tht8 = {{13{r_tht[15]}}, r_tht, 3'b000};
    assign w_psi8 = {{13{r_psi[15]}}, r_psi, 3'b000};

    assign w_goff = 4'(5'(i_cmd.step) - 5'(gimbal_pkg::ST_MUL_A0));
    assign w_gain = gimbal_pkg::gain_q24(w_goff);

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.step)
            gimbal_pkg::ST_MUL_IPHI: begin
                w_mul_a = 32'(r_phi);
                w_mul_b = {6'b0, r_sample_period};
            end
            gimbal_pkg::ST_MUL_ITHT: begin
                w_mul_a = 32'(r_tht);
                w_mul_b = {6'b0, r_sample_period};
            end
            gimbal_pkg::ST_MUL_IPSI: begin
                w_mul_a = 32'(r_psi);
                w_mul_b = {6'b0, r_sample_period};
            end
            gimbal_pkg::ST_MUL_P: begin
                w_mul_a = 32'(r_roll_raw);
                w_mul_b = {6'b0, r_gyro_scale};
            end
            gimbal_pkg::ST_MUL_Q: begin
                w_mul_a = 32'(r_pitch_raw);
                w_mul_b = {6'b0, r_gyro_scale};
            end
            gimbal_pkg::ST_MUL_R: begin
                w_mul_a = 32'(r_yaw_raw);
                w_mul_b = {6'b0, r_gyro_scale};
            end
            gimbal_pkg::ST_MUL_A0, gimbal_pkg::ST_MUL_B0: begin
                w_mul_a = r_p;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_A1, gimbal_pkg::ST_MUL_B1: begin
                w_mul_a = r_q;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_A2, gimbal_pkg::ST_MUL_B2: begin
                w_mul_a = w_phi8;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_A3, gimbal_pkg::ST_MUL_B3: begin
                w_mul_a = w_tht8;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_A4, gimbal_pkg::ST_MUL_B4: begin
                w_mul_a = r_roll_int;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_A5, gimbal_pkg::ST_MUL_B5: begin
                w_mul_a = r_pitch_int;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_Y0: begin
                w_mul_a = r_r;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_Y1: begin
                w_mul_a = w_psi8;
                w_mul_b = w_gain;
            end
            gimbal_pkg::ST_MUL_Y2: begin
                w_mul_a = r_yaw_int;
                w_mul_b = w_gain;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // integrator update: one adder shared across the three axes
    always_comb begin
        case (i_cmd.step)
            gimbal_pkg::ST_MUL_ITHT: w_int_old = r_roll_int;
            gimbal_pkg::ST_MUL_IPSI: w_int_old = r_pitch_int;
            default:                 w_int_old = r_yaw_int;
        endcase
    end
    assign w_int_new = sat40(40'(w_int_old) + r_prod[60:21]);

    assign w_prod64  = 64'(r_prod);
    assign w_acc_sum = r_acc + w_prod64;
    assign w_round   = round_q24(r_acc);

    // start-mode mix: a = -2 roll_int + pitch_int, b = roll_int + 2 pitch_int
    assign w_st_a = sat40({{8{r_pitch_int[31]}}, r_pitch_int}
                          - {{7{r_roll_int[31]}}, r_roll_int, 1'b0});
    assign w_st_b = sat40({{8{r_roll_int[31]}}, r_roll_int}
                          + {{7{r_pitch_int[31]}}, r_pitch_int, 1'b0});

    assign w_beyond = beyond(r_cmd_a, r_ntrl_a, r_tilt_limit)
                   || beyond(r_cmd_b, r_ntrl_b, r_tilt_limit)
                   || beyond(r_cmd_y, r_ntrl_y, r_yaw_limit);

    // control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_scale    <= gimbal_pkg::GYRO_SCALE_RST;
            r_sample_period <= gimbal_pkg::SAMPLE_PERIOD_RST;
            r_tilt_limit    <= gimbal_pkg::LIMIT_RST;
            r_yaw_limit     <= gimbal_pkg::LIMIT_RST;
            r_roll_int      <= '0;
            r_pitch_int     <= '0;
            r_yaw_int       <= '0;
            r_ntrl_a        <= '0;
            r_ntrl_b        <= '0;
            r_ntrl_y        <= '0;
            r_fault         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gimbal_pkg::CFG_GYRO_SCALE:    r_gyro_scale    <= i_cfg_data[23:0];
                    gimbal_pkg::CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[23:0];
                    gimbal_pkg::CFG_TILT_LIMIT:    r_tilt_limit    <= i_cfg_data;
                    gimbal_pkg::CFG_YAW_LIMIT:     r_yaw_limit     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.run) begin
                case (i_cmd.step)
                    gimbal_pkg::ST_MUL_ITHT: r_roll_int  <= w_int_new;
                    gimbal_pkg::ST_MUL_IPSI: r_pitch_int <= w_int_new;
                    gimbal_pkg::ST_MUL_P:    r_yaw_int   <= w_int_new;
                    gimbal_pkg::ST_FINISH: begin
                        if (r_start) begin
                            r_ntrl_a <= w_st_a;
                            r_ntrl_b <= w_st_b;
                            r_ntrl_y <= r_yaw_int;
                        end
                    end
                    gimbal_pkg::ST_CHECK: begin
                        if (w_beyond) begin
                            r_fault <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_roll_raw  <= i_roll_rate_raw;
            r_pitch_raw <= i_pitch_rate_raw;
            r_yaw_raw   <= i_yaw_rate_raw;
            r_phi       <= i_roll_angle;
            r_tht       <= i_pitch_angle;
            r_psi       <= i_yaw_angle;
            r_start     <= i_starting;
        end

        r_prod <= w_mul_a * w_mul_b;

        if (i_cmd.run) begin
            case (i_cmd.step)
                gimbal_pkg::ST_MUL_Q:  r_p <= r_prod[39:8];
                gimbal_pkg::ST_MUL_R:  r_q <= r_prod[39:8];
                gimbal_pkg::ST_MUL_A0: r_r <= r_prod[39:8];
                gimbal_pkg::ST_MUL_A1: r_acc <= w_prod64;
                gimbal_pkg::ST_MUL_A2, gimbal_pkg::ST_MUL_A3, gimbal_pkg::ST_MUL_A4,
                gimbal_pkg::ST_MUL_A5, gimbal_pkg::ST_MUL_B0: r_acc <= w_acc_sum;
                gimbal_pkg::ST_MUL_B1: begin
                    r_cmd_a <= w_round;
                    r_acc   <= w_prod64;
                end
                gimbal_pkg::ST_MUL_B2, gimbal_pkg::ST_MUL_B3, gimbal_pkg::ST_MUL_B4,
                gimbal_pkg::ST_MUL_B5, gimbal_pkg::ST_MUL_Y0: r_acc <= w_acc_sum;
                gimbal_pkg::ST_MUL_Y1: begin
                    r_cmd_b <= w_round;
                    r_acc   <= w_prod64;
                end
                gimbal_pkg::ST_MUL_Y2, gimbal_pkg::ST_Y_LAST: r_acc <= w_acc_sum;
                gimbal_pkg::ST_ROUND_Y: r_cmd_y <= w_round;
                gimbal_pkg::ST_FINISH: begin
                    if (r_start) begin
                        r_cmd_a <= w_st_a;
                        r_cmd_b <= w_st_b;
                        r_cmd_y <= r_yaw_int;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.emit) begin
            o_coupled_cmd_a     <= r_fault ? 32'sd0 : r_cmd_a;
            o_coupled_cmd_b     <= r_fault ? 32'sd0 : r_cmd_b;
            o_yaw_motor_command <= r_fault ? 32'sd0 : r_cmd_y;
            o_fault             <= r_fault;
        end
    end

    assign o_stat.fault = r_fault;

endmodule

// ===== sv/gimbal_three_axis_pi_state_feedback_unit.sv =====
// ----------------------------------------------------------------------------
// gimbal_three_axis_pi_state_feedback_unit
// Three-axis gimbal state-feedback controller with integral action.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one attitude sample: three
//   raw gyro rates, roll/pitch/yaw angles and the starting bit. Output channel
//   (o_out_valid / i_out_stall) returns one item per sample: two coupled
//   roll/pitch motor commands, the yaw command and the sticky fault flag.
//   Config port: i_cfg_we with i_cfg_index (0 gyro_scale, 1 sample_period,
//   2 tilt_limit, 3 yaw_limit) and i_cfg_data; write only while idle.
// Schedule:
//   An item runs the step schedule through one shared 32x30 multiplier
//   (21 products, one per cycle, plus round/finish/check), and the
//   result is then moved into the output register, which raises
//   o_out_valid. Once the fault is latched the schedule is skipped: an
//   item goes straight to the done state and returns zeros.
//   One item is in flight; o_in_stall stays high until its result has been
//   moved into the output register.
// Reset (synchronous, i_rst_n low): integrators, neutrals and fault clear,
//   config returns to defaults, no output is valid.
// Stall: a result waits in the output register while i_out_stall is high;
//   the finished result behind it waits in the datapath, and the input
//   channel stalls until the output frees up.
// ----------------------------------------------------------------------------
module gimbal_three_axis_pi_state_feedback_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_roll_rate_raw,
    input  logic signed [15:0]                 i_pitch_rate_raw,
    input  logic signed [15:0]                 i_yaw_rate_raw,
    input  logic signed [15:0]                 i_roll_angle,
    input  logic signed [15:0]                 i_pitch_angle,
    input  logic signed [15:0]                 i_yaw_angle,
    input  logic                               i_starting,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [31:0]                 o_coupled_cmd_a,
    output logic signed [31:0]                 o_coupled_cmd_b,
    output logic signed [31:0]                 o_yaw_motor_command,
    output logic                               o_fault,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [gimbal_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gimbal_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gimbal_pkg::t_dp_cmd  w_cmd;   // sequencer -> datapath
    gimbal_pkg::t_dp_stat w_stat;  // datapath -> sequencer

    // sequencer: handshakes and schedule step
    gimbal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic, state and result registers
    gimbal_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_roll_rate_raw     (i_roll_rate_raw),
        .i_pitch_rate_raw    (i_pitch_rate_raw),
        .i_yaw_rate_raw      (i_yaw_rate_raw),
        .i_roll_angle        (i_roll_angle),
        .i_pitch_angle       (i_pitch_angle),
        .i_yaw_angle         (i_yaw_angle),
        .i_starting          (i_starting),
        .o_coupled_cmd_a     (o_coupled_cmd_a),
        .o_coupled_cmd_b     (o_coupled_cmd_b),
        .o_yaw_motor_command (o_yaw_motor_command),
        .o_fault             (o_fault)
    );

endmodule
